@@ src/domq_pkg.sv @@
// Shared types and codes for the deadline-ordered message queue.
// No dependencies; imported by every module of the block.
package domq_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_TIME_BITS   = 32;

   localparam int ID_BITS    = 16;
   localparam int DELAY_BITS = 24;
   localparam int FILL_BITS  = 5;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_POST   = 3'd1,
      OP_POLL   = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_PAUSE  = 3'd4,
      OP_RESUME = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_DELIVERED = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_NOT_DUE   = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   // receiver/message pair carried by each cell
   typedef struct packed {
      logic [ID_BITS-1:0] receiver;
      logic [ID_BITS-1:0] message;
   } payload_type;

   // per-beat command broadcast to every cell
   typedef struct packed {
      logic post;
      logic pop;
   } cell_cmd_type;

endpackage

@@ src/deadline_ordered_message_queue_core.sv @@
// Top level of the deadline-ordered message queue: control, time base and cell chain.
// Depends on domq_pkg and domq_cell.
//
//  channel | dir | beat contents (low bits first)
//  --------+-----+-----------------------------------------------------------
//  req_*   | in  | op[2:0], receiver_id[18:3], message_id[34:19], delay[58:35]
//  rsp_*   | out | status[2:0], out_receiver[18:3], out_message[34:19], fill[39:35]
//
// One request beat per cycle unless the rsp side stalls: each beat is resolved in the cycle it is taken.
// A post finds its slot through the keep chain running across all cells and
// every cell shifts in the same edge; a poll shifts the chain toward the head.
// The response sits in one output register; req_tready stays high while that
// register is empty or being drained, so a stalled rsp side stalls req only.
// reset (synchronous, active high) empties the queue, zeroes time, clears pause.
module deadline_ordered_message_queue_core #(
   parameter int QUEUE_DEPTH = domq_pkg::DEF_QUEUE_DEPTH,
   parameter int TIME_BITS   = domq_pkg::DEF_TIME_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // op[3], receiver_id[16], message_id[16], delay[24], pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[3], out_receiver[16], out_message[16], fill[5]
);
   import domq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // request fields
   op_type                op;
   payload_type           req_payload;
   logic [DELAY_BITS-1:0] req_delay;

   assign op                   = op_type'(req_tdata[2:0]);
   assign req_payload.receiver = req_tdata[18:3];
   assign req_payload.message  = req_tdata[34:19];
   assign req_delay            = req_tdata[58:35];

   // state
   logic [CW-1:0]        count_ff, count_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic                 paused_ff, paused_in;

   // response register
   logic                 rsp_valid_ff;
   status_type           status_ff, status_in;
   payload_type          out_ff, out_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;

   logic                 accept;
   cell_cmd_type         cmd;
   logic                 full;
   logic                 head_due;
   logic [TIME_BITS-1:0] head_diff;
   logic [TIME_BITS-1:0] due;
   logic [TIME_BITS+DELAY_BITS-1:0] delay_wide;
   logic [CW+FILL_BITS-1:0]         fill_wide;

   // cell chain wiring
   logic                 keep_w  [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] dl_w    [QUEUE_DEPTH];
   payload_type          pl_w    [QUEUE_DEPTH];
   logic                 occ_w   [QUEUE_DEPTH];

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   // delay reduced modulo 2^TIME_BITS (zero-extended or truncated)
   assign delay_wide = {{TIME_BITS{1'b0}}, req_delay};
   assign due        = now_ff + delay_wide[TIME_BITS-1:0];

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign head_diff = now_ff - dl_w[0];
   assign head_due  = ~head_diff[TIME_BITS-1];

   always_comb begin
      count_in  = count_ff;
      now_in    = now_ff;
      paused_in = paused_ff;
      status_in = ST_DONE;
      out_in    = '0;
      cmd       = '0;
      case (op)
         OP_TICK: begin
            if (!paused_ff) now_in = now_ff + 1'b1;
         end
         OP_POST: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.post = accept;
               count_in = count_ff + 1'b1;
            end
         end
         OP_POLL: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (!head_due) begin
               status_in = ST_NOT_DUE;
            end else begin
               status_in = ST_DELIVERED;
               out_in    = pl_w[0];
               cmd.pop   = accept;
               count_in  = count_ff - 1'b1;
            end
         end
         OP_CLEAR:  count_in  = '0;
         OP_PAUSE:  paused_in = 1'b1;
         OP_RESUME: paused_in = 1'b0;
         default: ;
      endcase
   end

   // fill is the low bits of the new count
   assign fill_wide = {{FILL_BITS{1'b0}}, count_in};
   assign fill_in   = fill_wide[FILL_BITS-1:0];

   // chain of cells, head at index 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign occ_w[i] = (CW'(i) < count_ff);
      if (i == 0) begin : g_head
         domq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
            .clock          (clock),
            .cmd            (cmd),
            .occupied       (occ_w[i]),
            .keep_prev      (1'b1),
            .new_deadline   (due),
            .new_payload    (req_payload),
            .left_deadline  (due),
            .left_payload   (req_payload),
            .right_deadline (dl_w[i+1]),
            .right_payload  (pl_w[i+1]),
            .keep_out       (keep_w[i]),
            .deadline       (dl_w[i]),
            .payload        (pl_w[i])
         );
      end else if (i == QUEUE_DEPTH - 1) begin : g_tail
         domq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
            .clock          (clock),
            .cmd            (cmd),
            .occupied       (occ_w[i]),
            .keep_prev      (keep_w[i-1]),
            .new_deadline   (due),
            .new_payload    (req_payload),
            .left_deadline  (dl_w[i-1]),
            .left_payload   (pl_w[i-1]),
            .right_deadline (dl_w[i]),
            .right_payload  (pl_w[i]),
            .keep_out       (keep_w[i]),
            .deadline       (dl_w[i]),
            .payload        (pl_w[i])
         );
      end else begin : g_mid
         domq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
            .clock          (clock),
            .cmd            (cmd),
            .occupied       (occ_w[i]),
            .keep_prev      (keep_w[i-1]),
            .new_deadline   (due),
            .new_payload    (req_payload),
            .left_deadline  (dl_w[i-1]),
            .left_payload   (pl_w[i-1]),
            .right_deadline (dl_w[i+1]),
            .right_payload  (pl_w[i+1]),
            .keep_out       (keep_w[i]),
            .deadline       (dl_w[i]),
            .payload        (pl_w[i])
         );
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         now_ff       <= '0;
         paused_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff  <= count_in;
            now_ff    <= now_in;
            paused_ff <= paused_in;
         end
         if (accept)          rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         out_ff    <= out_in;
         fill_ff   <= fill_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {fill_ff, out_ff.message, out_ff.receiver, status_ff};

endmodule

@@ src/domq_cell.sv @@
// One slot of the sorted chain: deadline plus payload, with insert/shift logic.
// Depends on domq_pkg.
module domq_cell #(
   parameter int TIME_BITS = domq_pkg::DEF_TIME_BITS
) (
   input  logic                   clock,
   input  domq_pkg::cell_cmd_type cmd,
   input  logic                   occupied,
   input  logic                   keep_prev,
   input  logic [TIME_BITS-1:0]   new_deadline,
   input  domq_pkg::payload_type  new_payload,
   input  logic [TIME_BITS-1:0]   left_deadline,
   input  domq_pkg::payload_type  left_payload,
   input  logic [TIME_BITS-1:0]   right_deadline,
   input  domq_pkg::payload_type  right_payload,
   output logic                   keep_out,
   output logic [TIME_BITS-1:0]   deadline,
   output domq_pkg::payload_type  payload
);
   import domq_pkg::*;

   logic [TIME_BITS-1:0] deadline_ff, deadline_in;
   payload_type          payload_ff, payload_in;
   logic [TIME_BITS-1:0] diff;
   logic                 stay;

   // entry stays ahead of the new one when its deadline is at or before it
   assign diff     = new_deadline - deadline_ff;
   assign stay     = occupied & ~diff[TIME_BITS-1];
   assign keep_out = keep_prev & stay;

   always_comb begin
      deadline_in = deadline_ff;
      payload_in  = payload_ff;
      if (cmd.post) begin
         if (keep_out) begin
            deadline_in = deadline_ff;
            payload_in  = payload_ff;
         end else if (keep_prev) begin
            deadline_in = new_deadline;
            payload_in  = new_payload;
         end else begin
            deadline_in = left_deadline;
            payload_in  = left_payload;
         end
      end else if (cmd.pop) begin
         deadline_in = right_deadline;
         payload_in  = right_payload;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      payload_ff  <= payload_in;
   end

   assign deadline = deadline_ff;
   assign payload  = payload_ff;

endmodule

@@ src/domq_checker.sv @@
// Port-level checks for the deadline-ordered message queue, bound to the top level.
// Depends on domq_pkg and deadline_ordered_message_queue_core.
module domq_checker #(
   parameter int QUEUE_DEPTH = domq_pkg::DEF_QUEUE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import domq_pkg::*;

   localparam logic [FILL_BITS-1:0] DEPTH_FILL = FILL_BITS'(QUEUE_DEPTH);
   localparam bit SMALL = (QUEUE_DEPTH < 32);

   logic [2:0]           st;
   logic [FILL_BITS-1:0] fill;

   assign st   = rsp_tdata[2:0];
   assign fill = rsp_tdata[39:35];

   // held beat stays put while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // only deliveries carry a receiver and message
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st != ST_DELIVERED |-> rsp_tdata[34:3] == '0)
      else $error("non-delivery beat carries payload");

   // rejection only when the queue is full (checked only when the depth fits in fill)
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == ST_FULL |-> !SMALL || fill == DEPTH_FILL)
      else $error("full status with room left");

   // empty status only when nothing is held
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == ST_EMPTY |-> fill == '0)
      else $error("empty status with entries held");

   // no beat comes out without a request taken the cycle before
   a_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("response without request");

endmodule

bind deadline_ordered_message_queue_core domq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_domq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/deadline_queue_checker.sv @@
// Checker for the deadline-ordered message queue: watches both stream channels,
// keeps its own sorted copy of the queue and compares every response beat.
// Depends on domq_pkg.
module deadline_queue_checker
   import domq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // op[3], receiver_id[16], message_id[16], delay[24], pad
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // status[3], out_receiver[16], out_message[16], fill[5]
   output int          fail_count,
   output int          outstanding
);

   localparam int DEPTH = DEF_QUEUE_DEPTH;

   typedef struct {
      status_type         status;
      logic [ID_BITS-1:0] receiver;
      logic [ID_BITS-1:0] message;
      logic [FILL_BITS-1:0] fill;
   } reply_t;

   logic [DEF_TIME_BITS-1:0] slot_due [DEPTH];
   logic [ID_BITS-1:0]       slot_rcv [DEPTH];
   logic [ID_BITS-1:0]       slot_msg [DEPTH];
   int                       held;
   logic [DEF_TIME_BITS-1:0] time_now;
   logic                     frozen;
   reply_t                   pending_replies[$];
   int                       errors = 0;

   // modular compare: a is at or before b
   function automatic logic no_later(input logic [DEF_TIME_BITS-1:0] a,
                                     input logic [DEF_TIME_BITS-1:0] b);
      logic [DEF_TIME_BITS-1:0] diff;
      diff = b - a;
      return !diff[DEF_TIME_BITS-1];
   endfunction

   // apply one request to the shadow queue, return the reply it must produce
   function automatic reply_t advance_queue(input logic [63:0] beat);
      logic [2:0]               op;
      logic [ID_BITS-1:0]       rcv;
      logic [ID_BITS-1:0]       msg;
      logic [DELAY_BITS-1:0]    dly;
      logic [DEF_TIME_BITS-1:0] due;
      int                       pos;
      int                       i;
      reply_t                   r;
      op  = beat[2:0];
      rcv = beat[18:3];
      msg = beat[34:19];
      dly = beat[58:35];
      r.status   = ST_DONE;
      r.receiver = '0;
      r.message  = '0;
      case (op)
         OP_TICK: begin
            if (!frozen) time_now = time_now + 1'b1;
         end
         OP_POST: begin
            if (held >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               due = time_now + DEF_TIME_BITS'(dly);
               pos = 0;
               while (pos < held && no_later(slot_due[pos], due)) pos++;
               for (i = held; i > pos; i--) begin
                  slot_due[i] = slot_due[i-1];
                  slot_rcv[i] = slot_rcv[i-1];
                  slot_msg[i] = slot_msg[i-1];
               end
               slot_due[pos] = due;
               slot_rcv[pos] = rcv;
               slot_msg[pos] = msg;
               held++;
            end
         end
         OP_POLL: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else if (!no_later(slot_due[0], time_now)) begin
               r.status = ST_NOT_DUE;
            end else begin
               r.status   = ST_DELIVERED;
               r.receiver = slot_rcv[0];
               r.message  = slot_msg[0];
               for (i = 1; i < held; i++) begin
                  slot_due[i-1] = slot_due[i];
                  slot_rcv[i-1] = slot_rcv[i];
                  slot_msg[i-1] = slot_msg[i];
               end
               held--;
            end
         end
         OP_CLEAR:  held = 0;
         OP_PAUSE:  frozen = 1'b1;
         OP_RESUME: frozen = 1'b0;
         default: ;
      endcase
      r.fill = FILL_BITS'(held);
      return r;
   endfunction

   always @(posedge clock) begin : track
      reply_t want;
      if (reset) begin
         held     = 0;
         time_now = '0;
         frozen   = 1'b0;
         pending_replies.delete();
      end else begin
         // response first: it belongs to an earlier request
         if (rsp_tvalid && rsp_tready) begin
            if (pending_replies.size() == 0) begin
               $error("response beat with no request outstanding: %h", rsp_tdata);
               errors++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_tdata[2:0] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[2:0]);
                  errors++;
               end
               if (rsp_tdata[18:3] !== want.receiver) begin
                  $error("out_receiver: expected %0h, got %0h", want.receiver,
                         rsp_tdata[18:3]);
                  errors++;
               end
               if (rsp_tdata[34:19] !== want.message) begin
                  $error("out_message: expected %0h, got %0h", want.message,
                         rsp_tdata[34:19]);
                  errors++;
               end
               if (rsp_tdata[39:35] !== want.fill) begin
                  $error("fill: expected %0d, got %0d", want.fill, rsp_tdata[39:35]);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) pending_replies.push_back(advance_queue(req_tdata));
      end
      outstanding <= pending_replies.size();
      fail_count  <= errors;
   end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for deadline_ordered_message_queue_core: clock, reset, request
// stimulus, response back-pressure and the verdict. Depends on domq_pkg,
// deadline_queue_checker and the block itself.
module tb_top;
   import domq_pkg::*;

   // op codes the block must treat as no-ops
   localparam logic [2:0] OP_UNUSED_A = 3'd6;
   localparam logic [2:0] OP_UNUSED_B = 3'd7;

   localparam int PHASES        = 19;
   localparam int PHASE_ITEMS   = 100;
   localparam int HOLD_CYCLES   = 60;    // receiver hold-off length
   localparam int STALL_LIMIT   = 1000;  // cycles with no beat on either side
   localparam int SETTLE_CYCLES = 4;     // block answers in the cycle after a beat is taken

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [63:0] req_tdata  = '0;   // op[3], receiver_id[16], message_id[16], delay[24], pad
   logic        req_tready;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // status[3], out_receiver[16], out_message[16], fill[5]

   // calm: no idling on either side; hold_token: bumped to ask for a hold-off
   logic calm       = 1'b0;
   int   hold_token = 0;
   int   seen_token = 0;
   int   hold_left  = 0;

   int fail_count;
   int outstanding;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   deadline_ordered_message_queue_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   deadline_queue_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Response side: random stalls about a quarter of the time, none while calm.
   // A new hold_token starts a long hold-off so the single output register
   // fills and req_tready drops while the sender keeps offering beats.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_token != seen_token) begin
         seen_token <= hold_token;
         hold_left  <= HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= 25);
      end
   end

   // Watchdog: ends the run as a failure when beats stop moving on both sides.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("FAIL deadline_ordered_message_queue_core");
      $finish;
   end

   function automatic logic [63:0] pack_req(input logic [2:0] op,
                                            input logic [ID_BITS-1:0] rcv,
                                            input logic [ID_BITS-1:0] msg,
                                            input logic [DELAY_BITS-1:0] dly);
      return {5'b0, dly, msg, rcv, op};
   endfunction

   // Present one beat and wait for it to be taken; then maybe idle a little.
   // A gap follows about one beat in eight: roughly a quarter of the time idle.
   // Called just after a rising edge.
   task automatic offer(input logic [63:0] beat);
      int gap;
      req_tdata  <= beat;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!calm && $urandom_range(0, 99) < 13) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic offer_op(input logic [2:0] op);
      offer(pack_req(op, ID_BITS'($urandom()), ID_BITS'($urandom()),
                     DELAY_BITS'($urandom())));
   endtask

   // Sender goes quiet until every outstanding response has arrived.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // One random beat. Delays are mostly short so polls find due heads;
   // a few are huge or at the field extremes.
   task automatic random_item(input int post_w, input int poll_w);
      int                    roll;
      logic [2:0]            op;
      logic [DELAY_BITS-1:0] dly;
      roll = $urandom_range(0, 99);
      if (roll < post_w) begin
         op = OP_POST;
      end else if (roll < post_w + poll_w) begin
         op = OP_POLL;
      end else if (roll < 94) begin
         op = OP_TICK;
      end else begin
         case ($urandom_range(0, 5))
            0:       op = OP_CLEAR;
            1, 2:    op = OP_PAUSE;
            3, 4:    op = OP_RESUME;
            default: op = $urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B;
         endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 70)      dly = DELAY_BITS'($urandom_range(0, 6));
      else if (roll < 85) dly = DELAY_BITS'($urandom_range(0, 40));
      else if (roll < 95) dly = DELAY_BITS'($urandom());
      else                dly = $urandom_range(0, 1) ? '1 : '0;
      offer(pack_req(op, ID_BITS'($urandom()), ID_BITS'($urandom()), dly));
   endtask

   initial begin : stimulus
      int phase;
      int n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      offer(pack_req(OP_POLL, '0, '0, '0));               // empty queue
      offer(pack_req(OP_POST, '0, '0, '0));               // due right away, all-zero fields
      offer(pack_req(OP_POLL, '0, '0, '0));               // delivered
      offer(pack_req(OP_POST, '1, '1, '1));               // farthest deadline, all-ones fields
      offer(pack_req(OP_POLL, '0, '0, '0));               // head not due
      offer(pack_req(OP_POST, 16'h0001, 16'h00aa, 24'd2));
      offer(pack_req(OP_POST, 16'h0002, 16'h00bb, 24'd2)); // equal deadline goes behind
      offer(pack_req(OP_POST, 16'h0003, 16'h00cc, 24'd1)); // earlier, goes to the head
      offer(pack_req(OP_PAUSE, '0, '0, '0));
      offer(pack_req(OP_TICK, '0, '0, '0));               // frozen time
      offer(pack_req(OP_PAUSE, '0, '0, '0));              // pause while paused
      offer(pack_req(OP_POLL, '0, '0, '0));               // not due on frozen time
      offer(pack_req(OP_RESUME, '0, '0, '0));
      offer(pack_req(OP_RESUME, '0, '0, '0));             // resume while running
      offer(pack_req(OP_TICK, '0, '0, '0));
      offer(pack_req(OP_POLL, '0, '0, '0));               // earliest post
      offer(pack_req(OP_TICK, '0, '0, '0));
      offer(pack_req(OP_POLL, '0, '0, '0));               // first of the equal pair
      offer(pack_req(OP_POLL, '0, '0, '0));               // second of the equal pair
      offer(pack_req(OP_POLL, '0, '0, '0));               // far entry still not due
      offer_op(OP_UNUSED_A);
      offer_op(OP_UNUSED_B);
      offer(pack_req(OP_CLEAR, '0, '0, '0));
      offer(pack_req(OP_POLL, '0, '0, '0));               // empty after clear
      offer(pack_req(OP_TICK, '0, '0, '0));
      drain();

      // ---- random part: phases that fill, balance or empty the queue ----
      for (phase = 0; phase < PHASES; phase++) begin
         calm <= (phase == 4);
         if (phase == 1 || phase == 10) hold_token <= hold_token + 1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            case (phase % 3)
               0:       random_item(30, 30);
               1:       random_item(60, 15);   // fills up, reaches full rejects
               default: random_item(15, 55);   // drains, delivers
            endcase
         end
         if (phase == 2 || phase == 8 || phase == 14) drain();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("PASS deadline_ordered_message_queue_core");
      else $display("FAIL deadline_ordered_message_queue_core");
      $finish;
   end

endmodule

@@ files.f @@
src/domq_pkg.sv
src/domq_cell.sv
src/deadline_ordered_message_queue_core.sv
src/domq_checker.sv
tb/deadline_queue_checker.sv
tb/tb_top.sv
